// ----- rtl/core/deadband_piecewise_linear_map_defines.svh -----
// ----------------------------------------------------------------------------
// deadband_piecewise_linear_map_defines
// assertion macros shared by the checker of the dead band curve map
// ----------------------------------------------------------------------------
`ifndef DEADBAND_PIECEWISE_LINEAR_MAP_DEFINES_SVH
`define DEADBAND_PIECEWISE_LINEAR_MAP_DEFINES_SVH

// same-cycle implication, off while reset is high
`define DBPLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define DBPLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dbplm_pkg.sv -----
// ----------------------------------------------------------------------------
// dbplm_pkg
// widths, codes, beat types and the divider step of the dead band curve map
// ----------------------------------------------------------------------------
package dbplm_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int FRAC_BITS   = 8;
  localparam int X_BITS      = 10;
  localparam int HALF_BITS   = 9;
  localparam int Y_BITS      = 16;
  localparam int OUT_BITS    = 24;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // signed width of a curve x point, center plus half width included
  localparam int XW        = ((SAMPLE_BITS > X_BITS) ? SAMPLE_BITS : X_BITS) + 2;
  localparam int DX_BITS   = XW + 1;
  localparam int DY_BITS   = Y_BITS + 1;
  localparam int PROD_BITS = DY_BITS + DX_BITS;
  localparam int NUM_BITS  = PROD_BITS + FRAC_BITS;
  localparam int DIV_STEP  = 4;
  localparam int DIV_STAGES = (NUM_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int QW        = DIV_STAGES * DIV_STEP;
  localparam int QSW       = QW + 1;
  localparam int RW        = QW + 2;

  localparam logic signed [RW-1:0] RES_MAX = RW'((2 ** (OUT_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] RES_MIN = RW'(-(2 ** (OUT_BITS - 1)));

  typedef enum logic [1:0] {
    SEG_LOW  = 2'd0,
    SEG_DEAD = 2'd1,
    SEG_HIGH = 2'd2
  } seg_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEFT_END_X      = 3'd0,
    REG_RIGHT_END_X     = 3'd1,
    REG_CENTER_HOME     = 3'd2,
    REG_DEAD_HALF_WIDTH = 3'd3,
    REG_OUT_LEFT        = 3'd4,
    REG_OUT_DEAD_LOW    = 3'd5,
    REG_OUT_DEAD_HIGH   = 3'd6,
    REG_OUT_RIGHT       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [X_BITS-1:0]        left_end_x;
    logic [X_BITS-1:0]        right_end_x;
    logic [X_BITS-1:0]        center_home;
    logic [HALF_BITS-1:0]     dead_half_width;
    logic signed [Y_BITS-1:0] out_left;
    logic signed [Y_BITS-1:0] out_dead_low;
    logic signed [Y_BITS-1:0] out_dead_high;
    logic signed [Y_BITS-1:0] out_right;
  } cfg_t;

  typedef struct packed {
    logic [PROD_BITS-1:0]     nmag;
    logic [DX_BITS-1:0]       dmag;
    logic                     neg;
    logic                     degen;
    seg_e                     seg;
    logic signed [Y_BITS-1:0] ya;
  } front_beat_t;

  typedef struct packed {
    logic [QW-1:0]            num;
    logic [QW-1:0]            quot;
    logic [DX_BITS-1:0]       rem;
    logic [DX_BITS-1:0]       dmag;
    logic                     neg;
    logic                     degen;
    seg_e                     seg;
    logic signed [Y_BITS-1:0] ya;
  } div_stage_t;

  typedef struct packed {
    logic [QW-1:0]            quot;
    logic                     neg;
    logic                     degen;
    seg_e                     seg;
    logic signed [Y_BITS-1:0] ya;
  } div_beat_t;

  // restoring division, DIV_STEP quotient bits
  function automatic div_stage_t div_step(input div_stage_t d);
    div_stage_t o;
    logic [DX_BITS:0] rw;
    o = d;
    for (int i = 0; i < DIV_STEP; i++) begin
      rw = {o.rem, o.num[QW-1]};
      o.num = {o.num[QW-2:0], 1'b0};
      if (rw >= {1'b0, o.dmag}) begin
        o.rem  = DX_BITS'(rw - {1'b0, o.dmag});
        o.quot = {o.quot[QW-2:0], 1'b1};
      end else begin
        o.rem  = rw[DX_BITS-1:0];
        o.quot = {o.quot[QW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/dbplm_front.sv -----
// ----------------------------------------------------------------------------
// dbplm_front
// segment select, differences, product and magnitudes in four stages
// ----------------------------------------------------------------------------
module dbplm_front import dbplm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output front_beat_t            out_beat
);

  logic [3:0] vld;
  logic [3:0] en;

  logic signed [XW-1:0] s_x, px1, px2;
  logic signed [XW-1:0] xa_next, xb_next;
  logic signed [Y_BITS-1:0] ya_next, yb_next;
  seg_e seg_next;

  logic signed [XW-1:0]     s1, xa1, xb1;
  logic signed [Y_BITS-1:0] ya1, yb1;
  seg_e                     seg1;

  logic signed [DX_BITS-1:0] dx2, ds2;
  logic signed [DY_BITS-1:0] dy2;
  logic signed [Y_BITS-1:0]  ya2;
  seg_e                      seg2;

  logic signed [PROD_BITS-1:0] prod3;
  logic [DX_BITS-1:0]          dmag3;
  logic                        dneg3, degen3;
  logic signed [Y_BITS-1:0]    ya3;
  seg_e                        seg3;

  assign en[3] = !vld[3] || out_ready;
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  // inner points and segment choice
  always_comb begin
    s_x = signed'(XW'(sample));
    px1 = signed'(XW'(cfg.center_home)) - signed'(XW'(cfg.dead_half_width));
    px2 = signed'(XW'(cfg.center_home)) + signed'(XW'(cfg.dead_half_width));
    priority if (s_x <= px1) begin
      seg_next = SEG_LOW;
      xa_next  = signed'(XW'(cfg.left_end_x));
      xb_next  = px1;
      ya_next  = cfg.out_left;
      yb_next  = cfg.out_dead_low;
    end else if (s_x <= px2) begin
      seg_next = SEG_DEAD;
      xa_next  = px1;
      xb_next  = px2;
      ya_next  = cfg.out_dead_low;
      yb_next  = cfg.out_dead_high;
    end else begin
      seg_next = SEG_HIGH;
      xa_next  = px2;
      xb_next  = signed'(XW'(cfg.right_end_x));
      ya_next  = cfg.out_dead_high;
      yb_next  = cfg.out_right;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1   <= s_x;
      xa1  <= xa_next;
      xb1  <= xb_next;
      ya1  <= ya_next;
      yb1  <= yb_next;
      seg1 <= seg_next;
    end
    if (en[1]) begin
      dx2  <= DX_BITS'(xb1) - DX_BITS'(xa1);
      ds2  <= DX_BITS'(s1) - DX_BITS'(xa1);
      dy2  <= DY_BITS'(yb1) - DY_BITS'(ya1);
      ya2  <= ya1;
      seg2 <= seg1;
    end
    if (en[2]) begin
      prod3  <= PROD_BITS'(dy2) * PROD_BITS'(ds2);
      dmag3  <= dx2[DX_BITS-1] ? DX_BITS'(-dx2) : DX_BITS'(dx2);
      dneg3  <= dx2[DX_BITS-1];
      degen3 <= (dx2 == '0);
      ya3    <= ya2;
      seg3   <= seg2;
    end
    if (en[3]) begin
      out_beat.nmag  <= prod3[PROD_BITS-1] ? PROD_BITS'(-prod3) : PROD_BITS'(prod3);
      out_beat.neg   <= prod3[PROD_BITS-1] ^ dneg3;
      out_beat.dmag  <= dmag3;
      out_beat.degen <= degen3;
      out_beat.seg   <= seg3;
      out_beat.ya    <= ya3;
    end
  end

endmodule

// ----- rtl/core/dbplm_div.sv -----
// ----------------------------------------------------------------------------
// dbplm_div
// pipelined unsigned divider, DIV_STEP (four) quotient bits per stage
// ----------------------------------------------------------------------------
module dbplm_div import dbplm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  front_beat_t in_beat,
  output logic        out_valid,
  input  logic        out_ready,
  output div_beat_t   out_beat
);

  div_stage_t            st [DIV_STAGES];
  div_stage_t            first;
  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES-1:0] en;

  always_comb begin
    first.num   = QW'(in_beat.nmag) << FRAC_BITS;
    first.quot  = '0;
    first.rem   = '0;
    first.dmag  = in_beat.dmag;
    first.neg   = in_beat.neg;
    first.degen = in_beat.degen;
    first.seg   = in_beat.seg;
    first.ya    = in_beat.ya;
  end

  assign en[DIV_STAGES-1] = !vld[DIV_STAGES-1] || out_ready;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k < DIV_STAGES - 1) begin : g_en
      assign en[k] = !vld[k] || en[k+1];
    end
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en[k]) begin
          vld[k] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en[k]) st[k] <= div_step(first);
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en[k]) st[k] <= div_step(st[k-1]);
      end
    end
  end

  assign in_ready       = en[0];
  assign out_valid      = vld[DIV_STAGES-1];
  assign out_beat.quot  = st[DIV_STAGES-1].quot;
  assign out_beat.neg   = st[DIV_STAGES-1].neg;
  assign out_beat.degen = st[DIV_STAGES-1].degen;
  assign out_beat.seg   = st[DIV_STAGES-1].seg;
  assign out_beat.ya    = st[DIV_STAGES-1].ya;

endmodule

// ----- rtl/core/dbplm_back.sv -----
// ----------------------------------------------------------------------------
// dbplm_back
// quotient sign, offset add, 24-bit clamp and output register
// ----------------------------------------------------------------------------
module dbplm_back import dbplm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  div_beat_t                  in_beat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] mapped_value,
  output logic [1:0]                 segment,
  output logic                       degenerate,
  output logic                       saturated
);

  logic [1:0] vld;
  logic [1:0] en;

  logic signed [QSW-1:0]    qs;
  logic signed [Y_BITS-1:0] ya1;
  logic                     degen1;
  seg_e                     seg1;
  logic signed [RW-1:0]     r;

  assign en[1] = !vld[1] || out_ready;
  assign en[0] = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
    end
  end

  assign r = (RW'(ya1) <<< FRAC_BITS) + RW'(qs);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      priority if (in_beat.degen) begin
        qs <= '0;
      end else if (in_beat.neg) begin
        qs <= -signed'({1'b0, in_beat.quot});
      end else begin
        qs <= signed'({1'b0, in_beat.quot});
      end
      ya1    <= in_beat.ya;
      degen1 <= in_beat.degen;
      seg1   <= in_beat.seg;
    end
    if (en[1]) begin
      priority if (r > RES_MAX) begin
        mapped_value <= RES_MAX[OUT_BITS-1:0];
        saturated    <= 1'b1;
      end else if (r < RES_MIN) begin
        mapped_value <= RES_MIN[OUT_BITS-1:0];
        saturated    <= 1'b1;
      end else begin
        mapped_value <= r[OUT_BITS-1:0];
        saturated    <= 1'b0;
      end
      segment    <= seg1;
      degenerate <= degen1;
    end
  end

endmodule

// ----- rtl/core/deadband_piecewise_linear_map.sv -----
// ----------------------------------------------------------------------------
// deadband_piecewise_linear_map
// joystick axis map through a three-segment curve with a dead band
// ----------------------------------------------------------------------------
// Takes one sample beat per cycle while the result side keeps up, and returns
// one result beat per sample, in order, through four front stages (segment
// select, differences, multiply, magnitudes), ten divider stages of four
// quotient bits each, and two back stages (sign and offset add, clamp into the
// output register). Each stage advances on its own, so empty stages fill while
// a result waits. Registers 0..7 are written over the cfg port (cfg_ready is
// always high) and must only change while no sample is in flight.
module deadband_piecewise_linear_map import dbplm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic [SAMPLE_BITS-1:0]     sample,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic signed [OUT_BITS-1:0] mapped_value,
  output logic [1:0]                 segment,
  output logic                       degenerate,
  output logic                       saturated
);

  cfg_t        cfg;
  logic        front_valid, front_ready;
  front_beat_t front_beat;
  logic        div_valid, div_ready;
  div_beat_t   div_beat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_end_x      <= X_BITS'(0);
      cfg.right_end_x     <= X_BITS'(1023);
      cfg.center_home     <= X_BITS'(512);
      cfg.dead_half_width <= HALF_BITS'(10);
      cfg.out_left        <= -Y_BITS'(100);
      cfg.out_dead_low    <= '0;
      cfg.out_dead_high   <= '0;
      cfg.out_right       <= Y_BITS'(100);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_LEFT_END_X:      cfg.left_end_x      <= cfg_data[X_BITS-1:0];
        REG_RIGHT_END_X:     cfg.right_end_x     <= cfg_data[X_BITS-1:0];
        REG_CENTER_HOME:     cfg.center_home     <= cfg_data[X_BITS-1:0];
        REG_DEAD_HALF_WIDTH: cfg.dead_half_width <= cfg_data[HALF_BITS-1:0];
        REG_OUT_LEFT:        cfg.out_left        <= signed'(cfg_data[Y_BITS-1:0]);
        REG_OUT_DEAD_LOW:    cfg.out_dead_low    <= signed'(cfg_data[Y_BITS-1:0]);
        REG_OUT_DEAD_HIGH:   cfg.out_dead_high   <= signed'(cfg_data[Y_BITS-1:0]);
        REG_OUT_RIGHT:       cfg.out_right       <= signed'(cfg_data[Y_BITS-1:0]);
        default: ;
      endcase
    end
  end

  dbplm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample_valid),
    .in_ready  (sample_ready),
    .sample    (sample),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_beat  (front_beat)
  );

  dbplm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_beat   (front_beat),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_beat  (div_beat)
  );

  dbplm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (div_valid),
    .in_ready     (div_ready),
    .in_beat      (div_beat),
    .out_valid    (result_valid),
    .out_ready    (result_ready),
    .mapped_value (mapped_value),
    .segment      (segment),
    .degenerate   (degenerate),
    .saturated    (saturated)
  );

endmodule

// ----- rtl/core/dbplm_check.sv -----
// ----------------------------------------------------------------------------
// dbplm_check
// port-level checks of the dead band curve map, bound to the top level
// ----------------------------------------------------------------------------
`include "deadband_piecewise_linear_map_defines.svh"

module dbplm_check (
  input logic               clk,
  input logic               rst,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [15:0]        cfg_data,
  input logic               sample_valid,
  input logic               sample_ready,
  input logic [9:0]         sample,
  input logic               result_valid,
  input logic               result_ready,
  input logic signed [23:0] mapped_value,
  input logic [1:0]         segment,
  input logic               degenerate,
  input logic               saturated
);

  // a stalled result beat holds
  `DBPLM_ASSERT_NEXT(a_result_hold, !rst && result_valid && !result_ready, rst || (result_valid && $stable(mapped_value) && $stable(segment) && $stable(degenerate) && $stable(saturated)), "result beat changed while stalled")

  // reset empties the pipeline
  `DBPLM_ASSERT_NEXT(a_reset_empty, rst, !result_valid, "result beat right after reset")

  `DBPLM_ASSERT_NOW(a_segment_code, result_valid, segment != 2'd3, "segment code out of range")

  // a clamped value sits on one of the two limits
  `DBPLM_ASSERT_NOW(a_sat_limit, result_valid && saturated, mapped_value == 24'sh7fffff || mapped_value == -24'sh800000, "saturated value not at a limit")

endmodule

bind deadband_piecewise_linear_map dbplm_check u_check (.*);
